// File: rtl/core/slam_pkg.sv
// Shared types and constants for the serial link activity monitor.
`default_nettype none

package slam_pkg;

    // Link and field sizes
    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int CNT_W      = 32;
    localparam int RUN_W      = 4;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_PERIODS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_TIMEOUT  = 2'd2;

    // Configuration reset values
    localparam logic [MS_W-1:0]  RST_REPORT_PERIOD = 16'd500;
    localparam logic [RUN_W-1:0] RST_OK_PERIODS    = 4'd3;
    localparam logic [MS_W-1:0]  RST_LOST_TIMEOUT  = 16'd1500;

    // Event kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Last channel of a report walk
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        LINK_WAIT = 2'd0,
        LINK_RX   = 2'd1,
        LINK_OK   = 2'd2,
        LINK_LOST = 2'd3
    } link_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPORT
    } fsm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic            byte_inc;
        logic            tick;
        logic            due_load;
        logic            judge;
        logic [CH_W-1:0] ch;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic due;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/serial_link_activity_monitor_unit.sv
// Serial link activity monitor: four receive links, byte counts and periodic status reports.
// Order: byte and tick transactions are taken in the idle state; a tick is checked for a
// due report in the cycle after it; the first report transaction is then registered.
// Throughput: byte events one per cycle while idle; a reporting tick walks the channels
// one per cycle through the shared judge unit while the output register can take a report.
// Reset (aresetn, synchronous, active low) clears clock, counters and history, and
// loads the configuration defaults; no clearing pass is needed.
`default_nettype none

module serial_link_activity_monitor_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [slam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slam_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_func,
    input  wire logic [1:0]                      s_channel,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_report_channel,
    output logic [31:0]                          m_byte_total,
    output logic [1:0]                           m_link_status,
    output logic                                 m_last
);

    slam_pkg::dp_cmd_t    cmd;
    slam_pkg::dp_status_t status;

    // Controller
    slam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath
    slam_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_channel        (s_channel),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_report_channel (m_report_channel),
        .m_byte_total     (m_byte_total),
        .m_link_status    (m_link_status),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

// File: rtl/core/slam_ctrl.sv
// Controller state machine: event dispatch, report check and channel walk.
`default_nettype none

module slam_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_func,
    input  wire slam_pkg::dp_status_t status,
    output slam_pkg::dp_cmd_t         cmd
);

    slam_pkg::fsm_state_t           state_reg, state_next;
    logic [slam_pkg::CH_W-1:0]      idx_reg, idx_next;

    // State and channel index registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slam_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_ready      = 1'b0;
        cmd.byte_inc = 1'b0;
        cmd.tick     = 1'b0;
        cmd.due_load = 1'b0;
        cmd.judge    = 1'b0;
        cmd.ch       = idx_reg;
        unique case (state_reg)
            slam_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == slam_pkg::FUNC_TICK) begin
                        cmd.tick   = 1'b1;
                        state_next = slam_pkg::ST_CHECK;
                    end else begin
                        cmd.byte_inc = 1'b1;
                    end
                end
            end
            slam_pkg::ST_CHECK: begin
                if (status.due) begin
                    cmd.due_load = 1'b1;
                    idx_next     = '0;
                    state_next   = slam_pkg::ST_REPORT;
                end else begin
                    state_next = slam_pkg::ST_IDLE;
                end
            end
            slam_pkg::ST_REPORT: begin
                // Advance one channel whenever the output register can take it
                if (status.out_free) begin
                    cmd.judge = 1'b1;
                    if (idx_reg == slam_pkg::LAST_CH) begin
                        state_next = slam_pkg::ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = slam_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/slam_dp.sv
// Datapath: configuration, clock, per-channel counters, status judge, output register.
`default_nettype none

module slam_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [slam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [slam_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [slam_pkg::CH_W-1:0]         s_channel,
    input  wire slam_pkg::dp_cmd_t                 cmd,
    output slam_pkg::dp_status_t                   status,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [slam_pkg::CH_W-1:0]              m_report_channel,
    output logic [slam_pkg::CNT_W-1:0]             m_byte_total,
    output logic [1:0]                             m_link_status,
    output logic                                   m_last
);

    logic [slam_pkg::MS_W-1:0]   period_reg;
    logic [slam_pkg::RUN_W-1:0]  need_reg;
    logic [slam_pkg::MS_W-1:0]   timeout_reg;

    logic [slam_pkg::CNT_W-1:0]  now_reg;
    logic [slam_pkg::CNT_W-1:0]  next_rep_reg;

    logic [slam_pkg::CNT_W-1:0]  cnt_reg  [slam_pkg::CHANNELS];
    logic [slam_pkg::CNT_W-1:0]  prev_reg [slam_pkg::CHANNELS];
    logic [slam_pkg::CNT_W-1:0]  lgt_reg  [slam_pkg::CHANNELS];
    logic [slam_pkg::RUN_W-1:0]  run_reg  [slam_pkg::CHANNELS];

    logic                        m_valid_reg;
    logic [slam_pkg::CH_W-1:0]   out_ch_reg;
    logic [slam_pkg::CNT_W-1:0]  out_cnt_reg;
    slam_pkg::link_status_t      out_st_reg;
    logic                        out_last_reg;

    logic [slam_pkg::CNT_W-1:0]  due_diff;
    logic [slam_pkg::CNT_W-1:0]  cur_cnt;
    logic [slam_pkg::CNT_W-1:0]  cur_prev;
    logic [slam_pkg::CNT_W-1:0]  cur_lgt;
    logic [slam_pkg::RUN_W-1:0]  cur_run;
    logic [slam_pkg::CNT_W-1:0]  since_growth;
    logic                        growth;
    logic [slam_pkg::RUN_W-1:0]  run_inc;
    logic [slam_pkg::RUN_W-1:0]  run_next;
    slam_pkg::link_status_t      st_next;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= slam_pkg::RST_REPORT_PERIOD;
            need_reg    <= slam_pkg::RST_OK_PERIODS;
            timeout_reg <= slam_pkg::RST_LOST_TIMEOUT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                slam_pkg::CFG_REPORT_PERIOD: period_reg  <= cfg_data;
                slam_pkg::CFG_OK_PERIODS:    need_reg    <= cfg_data[slam_pkg::RUN_W-1:0];
                slam_pkg::CFG_LOST_TIMEOUT:  timeout_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Report due when now minus next report time is not negative
    assign due_diff = now_reg - next_rep_reg;

    // Millisecond clock and next report time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            next_rep_reg <= '0;
        end else begin
            if (cmd.tick) begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.due_load) begin
                next_rep_reg <= now_reg + slam_pkg::CNT_W'(period_reg);
            end
        end
    end

    // Judge the selected channel
    always_comb begin
        cur_cnt      = cnt_reg[cmd.ch];
        cur_prev     = prev_reg[cmd.ch];
        cur_lgt      = lgt_reg[cmd.ch];
        cur_run      = run_reg[cmd.ch];
        since_growth = now_reg - cur_lgt;
        growth       = cur_cnt > cur_prev;
        run_inc      = (cur_run < need_reg) ? cur_run + 1'b1 : cur_run;
        if (growth) begin
            run_next = run_inc;
            st_next  = (run_inc >= need_reg) ? slam_pkg::LINK_OK : slam_pkg::LINK_RX;
        end else if (cur_cnt == '0) begin
            run_next = '0;
            st_next  = slam_pkg::LINK_WAIT;
        end else if (since_growth >= slam_pkg::CNT_W'(timeout_reg)) begin
            run_next = '0;
            st_next  = slam_pkg::LINK_LOST;
        end else begin
            run_next = cur_run;
            st_next  = slam_pkg::LINK_RX;
        end
    end

    // Per-channel state: count bytes, update history on a judge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < slam_pkg::CHANNELS; i++) begin
                cnt_reg[i]  <= '0;
                prev_reg[i] <= '0;
                lgt_reg[i]  <= '0;
                run_reg[i]  <= '0;
            end
        end else begin
            if (cmd.byte_inc && (int'(s_channel) < slam_pkg::CHANNELS)) begin
                cnt_reg[s_channel] <= cnt_reg[s_channel] + 1'b1;
            end
            if (cmd.judge) begin
                prev_reg[cmd.ch] <= cur_cnt;
                run_reg[cmd.ch]  <= run_next;
                if (growth) begin
                    lgt_reg[cmd.ch] <= now_reg;
                end
            end
        end
    end

    // Output valid: set on a judge, drop once the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.judge) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (cmd.judge) begin
            out_ch_reg   <= cmd.ch;
            out_cnt_reg  <= cur_cnt;
            out_st_reg   <= st_next;
            out_last_reg <= (cmd.ch == slam_pkg::LAST_CH);
        end
    end

    assign status.due      = ~due_diff[slam_pkg::CNT_W-1];
    assign status.out_free = ~m_valid_reg | m_ready;

    assign m_valid          = m_valid_reg;
    assign m_report_channel = out_ch_reg;
    assign m_byte_total     = out_cnt_reg;
    assign m_link_status    = out_st_reg;
    assign m_last           = out_last_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_serial_link_activity_monitor_unit.sv
// Self-checking testbench for the serial link activity monitor unit.
`timescale 1ns / 100ps

module tb_serial_link_activity_monitor_unit;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CHUNK_ITEMS   = 38;
    localparam int MAX_GAP       = 40;

    // One channel entry of a status report
    typedef struct packed {
        logic [slam_pkg::CH_W-1:0]  channel;
        logic [slam_pkg::CNT_W-1:0] total;
        slam_pkg::link_status_t     status;
        logic                       last;
    } link_report_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [slam_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [slam_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic                            s_func    = slam_pkg::FUNC_BYTE;
    logic [1:0]                      s_channel = 2'd0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [1:0]                      m_report_channel;
    logic [31:0]                     m_byte_total;
    logic [1:0]                      m_link_status;
    logic                            m_last;

    // Idle rates in percent, hold-off control, run bookkeeping
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_toggle   = 1'b0;
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;
    int   cycle_count   = 0;
    int   mismatches    = 0;

    // Monitor state as predicted by the testbench
    logic [slam_pkg::MS_W-1:0]  period_ms;
    logic [slam_pkg::RUN_W-1:0] ok_needed;
    logic [slam_pkg::MS_W-1:0]  lost_ms;
    logic [31:0]                clock_ms;
    logic [31:0]                report_at_ms;
    logic [31:0]                rx_bytes    [slam_pkg::CHANNELS];
    logic [31:0]                prev_count  [slam_pkg::CHANNELS];
    logic [31:0]                growth_time [slam_pkg::CHANNELS];
    logic [slam_pkg::RUN_W-1:0] growth_run  [slam_pkg::CHANNELS];
    link_report_t               expected_reports[$];

    serial_link_activity_monitor_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_channel        (s_channel),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_report_channel (m_report_channel),
        .m_byte_total     (m_byte_total),
        .m_link_status    (m_link_status),
        .m_last           (m_last)
    );

    initial forever #10 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Clear the predicted state to its reset values
    task automatic reset_link_model;
        int c;
        period_ms    = slam_pkg::RST_REPORT_PERIOD;
        ok_needed    = slam_pkg::RST_OK_PERIODS;
        lost_ms      = slam_pkg::RST_LOST_TIMEOUT;
        clock_ms     = '0;
        report_at_ms = '0;
        for (c = 0; c < slam_pkg::CHANNELS; c++) begin
            rx_bytes[c]    = '0;
            prev_count[c]  = '0;
            growth_time[c] = '0;
            growth_run[c]  = '0;
        end
    endtask

    // Advance the predicted state by one event; queue the report a due tick causes
    function automatic void predict_link_event(logic func, logic [slam_pkg::CH_W-1:0] ch);
        logic [31:0]            since;
        slam_pkg::link_status_t st;
        int                     c;
        if (func == slam_pkg::FUNC_BYTE) begin
            rx_bytes[ch] = rx_bytes[ch] + 32'd1;
        end else begin
            clock_ms = clock_ms + 32'd1;
            since    = clock_ms - report_at_ms;
            if (!since[31]) begin
                report_at_ms = clock_ms + 32'(period_ms);
                for (c = 0; c < slam_pkg::CHANNELS; c++) begin
                    since = clock_ms - growth_time[c];
                    if (rx_bytes[c] > prev_count[c]) begin
                        // Saturate the run at the threshold
                        if (growth_run[c] < ok_needed)
                            growth_run[c] = growth_run[c] + 1'b1;
                        growth_time[c] = clock_ms;
                        st = (growth_run[c] >= ok_needed) ? slam_pkg::LINK_OK
                                                          : slam_pkg::LINK_RX;
                    end else if (rx_bytes[c] == 32'd0) begin
                        growth_run[c] = '0;
                        st = slam_pkg::LINK_WAIT;
                    end else if (since >= 32'(lost_ms)) begin
                        growth_run[c] = '0;
                        st = slam_pkg::LINK_LOST;
                    end else begin
                        st = slam_pkg::LINK_RX;
                    end
                    prev_count[c] = rx_bytes[c];
                    expected_reports.push_back('{channel: slam_pkg::CH_W'(c),
                                                 total:   rx_bytes[c],
                                                 status:  st,
                                                 last:    (c == slam_pkg::CHANNELS - 1)});
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Check each report transaction and pace the result channel
    always @(posedge aclk) begin : report_check
        link_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report: channel %0d total %0d status %0d last %0d",
                             $time, m_report_channel, m_byte_total, m_link_status, m_last);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_report_channel !== want.channel)
                        report_mismatch("report_channel", want.channel, m_report_channel);
                    if (m_byte_total !== want.total)
                        report_mismatch("byte_total", want.total, m_byte_total);
                    if (m_link_status !== want.status)
                        report_mismatch("link_status", want.status, m_link_status);
                    if (m_last !== want.last)
                        report_mismatch("last", want.last, m_last);
                end
            end
            // Start a long hold-off on request, else stall at random
            if (hold_toggle != hold_seen) begin
                hold_seen <= hold_toggle;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Offer one event transaction after a random gap; return at its acceptance edge
    task automatic send_event(input logic func, input logic [slam_pkg::CH_W-1:0] ch);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_channel <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_link_event(func, ch);
    endtask

    // Drop valid and wait until every queued report has come and the block is quiet
    task automatic drain_reports;
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [slam_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slam_pkg::CFG_DATA_W-1:0] value);
        drain_reports();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            slam_pkg::CFG_REPORT_PERIOD: period_ms = value;
            slam_pkg::CFG_OK_PERIODS:    ok_needed = value[slam_pkg::RUN_W-1:0];
            slam_pkg::CFG_LOST_TIMEOUT:  lost_ms   = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // First tick reports all links waiting; growth then climbs to OK at the reset threshold
    task automatic test_first_report;
        int c;
        write_reg(slam_pkg::CFG_REPORT_PERIOD, 16'd0);
        send_event(slam_pkg::FUNC_TICK, 2'd0);
        for (c = 0; c < slam_pkg::CHANNELS; c++)
            send_event(slam_pkg::FUNC_BYTE, slam_pkg::CH_W'(c));
        send_event(slam_pkg::FUNC_BYTE, 2'd3);
        send_event(slam_pkg::FUNC_TICK, 2'd3);
        repeat (2) begin
            send_event(slam_pkg::FUNC_BYTE, 2'd0);
            send_event(slam_pkg::FUNC_TICK, 2'd1);
        end
    endtask

    // Zero threshold gives OK on any growth; zero timeout makes idle links lost at once
    task automatic test_zero_settings;
        write_reg(slam_pkg::CFG_OK_PERIODS, 16'd0);
        write_reg(slam_pkg::CFG_LOST_TIMEOUT, 16'd0);
        send_event(slam_pkg::FUNC_BYTE, 2'd1);
        send_event(slam_pkg::FUNC_TICK, 2'd2);
        send_event(slam_pkg::FUNC_TICK, 2'd0);
    endtask

    // Build a run under the top threshold, then lower it and keep the run
    task automatic test_threshold_lowered;
        write_reg(slam_pkg::CFG_OK_PERIODS, 16'd15);
        write_reg(slam_pkg::CFG_LOST_TIMEOUT, 16'hFFFF);
        repeat (5) begin
            send_event(slam_pkg::FUNC_BYTE, 2'd2);
            send_event(slam_pkg::FUNC_TICK, 2'd1);
        end
        write_reg(slam_pkg::CFG_OK_PERIODS, 16'd1);
        send_event(slam_pkg::FUNC_BYTE, 2'd2);
        send_event(slam_pkg::FUNC_TICK, 2'd3);
    endtask

    // Random bytes and ticks over three idling phases, new settings every chunk
    task automatic test_random_traffic;
        int                        phase;
        int                        chunk;
        int                        n;
        logic [3:0]                active;
        logic [slam_pkg::CH_W-1:0] ch;
        active = 4'hF;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       set_idling(28, 88);
                1:       set_idling(88, 28);
                default: set_idling(0, 0);
            endcase
            for (chunk = 0; chunk < 3; chunk++) begin
                write_reg(slam_pkg::CFG_REPORT_PERIOD, ($urandom_range(3) == 0) ?
                          16'($urandom_range(13, 30)) : 16'($urandom_range(0, 12)));
                write_reg(slam_pkg::CFG_OK_PERIODS, 16'($urandom_range(0, 15)));
                write_reg(slam_pkg::CFG_LOST_TIMEOUT, ($urandom_range(4) == 0) ?
                          16'hFFFF : 16'($urandom_range(0, 24)));
                for (n = 0; n < CHUNK_ITEMS; n++) begin
                    // Let some links go quiet for a while so they age out
                    if (n % 10 == 0)
                        active = 4'($urandom_range(1, 15));
                    if ($urandom_range(99) < 40) begin
                        send_event(slam_pkg::FUNC_TICK, slam_pkg::CH_W'($urandom_range(3)));
                    end else begin
                        do ch = slam_pkg::CH_W'($urandom_range(3)); while (!active[ch]);
                        send_event(slam_pkg::FUNC_BYTE, ch);
                    end
                end
            end
        end
    endtask

    // Hold the result channel off while reporting ticks keep coming
    task automatic test_output_backpressure;
        int n;
        set_idling(0, 0);
        write_reg(slam_pkg::CFG_REPORT_PERIOD, 16'd0);
        hold_toggle <= ~hold_toggle;
        for (n = 0; n < 16; n++)
            send_event((n % 3 == 0) ? slam_pkg::FUNC_BYTE : slam_pkg::FUNC_TICK,
                       slam_pkg::CH_W'(n));
    endtask

    // Longest period: one more report, then the next tick is not due
    task automatic test_long_period;
        set_idling(28, 88);
        write_reg(slam_pkg::CFG_REPORT_PERIOD, 16'hFFFF);
        send_event(slam_pkg::FUNC_TICK, 2'd0);
        send_event(slam_pkg::FUNC_TICK, 2'd2);
        send_event(slam_pkg::FUNC_BYTE, 2'd3);
    endtask

    initial begin
        reset_link_model();
        set_idling(28, 88);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_report();
        test_zero_settings();
        test_threshold_lowered();
        test_random_traffic();
        test_output_backpressure();
        test_long_period();
        drain_reports();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
